>>> hdl/shcf_pkg.sv
// Shared types, codes and the byte-wide CRC-16-CCITT update for the sync header framer.
// No dependencies; imported by sync_header_crc_framer.
package shcf_pkg;

   // Item mode codes
   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_CLEAR   = 2'd2
   } mode_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_CRC_INITIAL = 2'd2
   } csr_index_type;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
   localparam logic [15:0] CRC_INITIAL_RESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'h1021;

   // Header byte positions within a start item
   localparam logic [2:0] HDR_SYNC_FIRST  = 3'd0;
   localparam logic [2:0] HDR_SYNC_SECOND = 3'd1;
   localparam logic [2:0] HDR_TYPE        = 3'd2;
   localparam logic [2:0] HDR_SEQUENCE    = 3'd3;
   localparam logic [2:0] HDR_LENGTH_LO   = 3'd4;
   localparam logic [2:0] HDR_LENGTH_HI   = 3'd5;
   localparam logic [2:0] HDR_CRC_LO      = 3'd6;
   localparam logic [2:0] HDR_CRC_HI      = 3'd7;

   // Result fields of one output item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       stray_error;
      logic       abandoned;
   } result_type;

   // One byte into CRC-16-CCITT, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/sync_header_crc_framer.sv
// Frame builder: six-byte header, payload pass-through and CRC-16-CCITT trailer.
// Depends on shcf_pkg (mode codes, register indexes, result struct, crc_feed).
//
// Usage:
//   req_* carries one item per valid/ready handshake: a start (type, length),
//   a payload byte, or a sequence clear. rsp_* delivers the framed byte stream,
//   one byte per handshake, with frame_end, run_last, stray_error and abandoned
//   flags. csr_* writes sync_first, sync_second and crc_initial; the user must
//   write them only while idle; the block does not enforce it. The first
//   result of an item passes the item register, then the result register,
//   before it is on rsp_*. One result per cycle while the receiver does not
//   stall; an item holds the item register until its last result leaves.
//   A start yields six results (eight with zero length), a payload byte one
//   (three when it closes the frame), a clear none. The byte sequencer drives
//   the single result register; the CRC is updated as each byte leaves.
//   Reset (synchronous) empties both registers, zeroes the sequence number,
//   closes any frame and restores the register defaults.
//   When the receiver stalls, the result register holds its item, the
//   sequencer waits and req_ready drops once the held item is pending.
module sync_header_crc_framer
   import shcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_frame_type,
   input  logic [15:0] req_frame_length,
   input  logic [7:0]  req_payload_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_stray_error,
   output logic        rsp_abandoned,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // configuration registers
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] crc_initial_ff;

   // held input item
   logic        item_valid_ff;
   logic [1:0]  item_mode_ff;
   logic [7:0]  item_type_ff;
   logic [15:0] item_length_ff;
   logic [7:0]  item_byte_ff;
   logic [2:0]  item_index_ff, item_index_in;

   // framing state
   logic [7:0]  sequence_ff, sequence_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] remaining_ff, remaining_in;
   logic        open_ff, open_in;

   // result register
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   // sequencer outputs
   result_type  result;
   logic        emits;
   logic        item_last;
   logic        can_emit;
   logic        item_done;
   logic        req_accept;
   logic [15:0] remaining_dec;

   assign can_emit      = !rsp_valid_ff || rsp_ready;
   assign remaining_dec = remaining_ff - 16'd1;

   // byte sequencer: what the current item gives at its current index
   always_comb begin
      result        = '0;
      emits         = 1'b0;
      item_last     = 1'b0;
      sequence_in   = sequence_ff;
      crc_in        = crc_ff;
      remaining_in  = remaining_ff;
      open_in       = open_ff;
      unique case (item_mode_ff)
         MODE_START: begin
            emits = 1'b1;
            unique case (item_index_ff)
               HDR_SYNC_FIRST: begin
                  result.out_byte  = sync_first_ff;
                  result.abandoned = open_ff;
                  crc_in           = crc_initial_ff;
               end
               HDR_SYNC_SECOND: begin
                  result.out_byte = sync_second_ff;
               end
               HDR_TYPE: begin
                  result.out_byte = item_type_ff;
                  crc_in          = crc_feed(crc_ff, item_type_ff);
               end
               HDR_SEQUENCE: begin
                  result.out_byte = sequence_ff;
                  crc_in          = crc_feed(crc_ff, sequence_ff);
                  sequence_in     = sequence_ff + 8'd1;
               end
               HDR_LENGTH_LO: begin
                  result.out_byte = item_length_ff[7:0];
                  crc_in          = crc_feed(crc_ff, item_length_ff[7:0]);
               end
               HDR_LENGTH_HI: begin
                  result.out_byte = item_length_ff[15:8];
                  crc_in          = crc_feed(crc_ff, item_length_ff[15:8]);
                  if (item_length_ff != 16'd0) begin
                     result.run_last = 1'b1;
                     item_last       = 1'b1;
                     open_in         = 1'b1;
                     remaining_in    = item_length_ff;
                  end
               end
               HDR_CRC_LO: begin
                  result.out_byte = crc_ff[7:0];
               end
               HDR_CRC_HI: begin
                  result.out_byte  = crc_ff[15:8];
                  result.frame_end = 1'b1;
                  result.run_last  = 1'b1;
                  item_last        = 1'b1;
                  open_in          = 1'b0;
                  remaining_in     = 16'd0;
               end
               default: ;
            endcase
         end
         MODE_PAYLOAD: begin
            emits = 1'b1;
            priority if (!open_ff) begin
               // stray byte: flag it, state untouched
               result.stray_error = 1'b1;
               result.run_last    = 1'b1;
               item_last          = 1'b1;
            end else if (item_index_ff == 3'd0) begin
               result.out_byte = item_byte_ff;
               crc_in          = crc_feed(crc_ff, item_byte_ff);
               remaining_in    = remaining_dec;
               if (remaining_dec != 16'd0) begin
                  result.run_last = 1'b1;
                  item_last       = 1'b1;
               end
            end else if (item_index_ff == 3'd1) begin
               result.out_byte = crc_ff[7:0];
            end else begin
               result.out_byte  = crc_ff[15:8];
               result.frame_end = 1'b1;
               result.run_last  = 1'b1;
               item_last        = 1'b1;
               open_in          = 1'b0;
               remaining_in     = 16'd0;
            end
         end
         MODE_CLEAR: begin
            item_last   = 1'b1;
            sequence_in = 8'd0;
         end
         default: begin
            item_last = 1'b1;
         end
      endcase
   end

   // an item leaves when its last byte goes out, or at once if it yields none
   assign item_done  = item_valid_ff && item_last && (!emits || can_emit);
   assign req_ready  = !item_valid_ff || item_done;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      item_index_in = item_index_ff;
      if (item_done) begin
         item_index_in = 3'd0;
      end else if (item_valid_ff && emits && can_emit) begin
         item_index_in = item_index_ff + 3'd1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         crc_initial_ff <= CRC_INITIAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_write_data[7:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_write_data[7:0];
            CSR_CRC_INITIAL: crc_initial_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // item register and framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         item_index_ff <= 3'd0;
         sequence_ff   <= 8'd0;
         crc_ff        <= CRC_INITIAL_RESET;
         remaining_ff  <= 16'd0;
         open_ff       <= 1'b0;
      end else begin
         item_index_ff <= item_index_in;
         if (req_accept) begin
            item_valid_ff <= 1'b1;
         end else if (item_done) begin
            item_valid_ff <= 1'b0;
         end
         if (item_valid_ff && (!emits || can_emit)) begin
            sequence_ff  <= sequence_in;
            crc_ff       <= crc_in;
            remaining_ff <= remaining_in;
            open_ff      <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_mode_ff   <= req_mode;
         item_type_ff   <= req_frame_type;
         item_length_ff <= req_frame_length;
         item_byte_ff   <= req_payload_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (can_emit) begin
         rsp_valid_ff <= item_valid_ff && emits;
      end
   end

   always_ff @(posedge clock) begin
      if (can_emit && item_valid_ff && emits) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_frame_end   = rsp_ff.frame_end;
   assign rsp_run_last    = rsp_ff.run_last;
   assign rsp_stray_error = rsp_ff.stray_error;
   assign rsp_abandoned   = rsp_ff.abandoned;

   // checks
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_end |-> rsp_ff.run_last)
      else $error("frame end without run_last");

   a_stray_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stray_error |->
         rsp_ff.run_last && (rsp_ff.out_byte == 8'd0) && !rsp_ff.frame_end)
      else $error("stray result malformed");

   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> (item_index_ff == 3'd0))
      else $error("byte index moved with no item held");

   a_closed_after_end: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && emits && can_emit && result.frame_end |=>
         !open_ff && (remaining_ff == 16'd0))
      else $error("frame still open after its crc");

   a_abandon_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.abandoned |->
         !rsp_ff.frame_end && !rsp_ff.stray_error && !rsp_ff.run_last)
      else $error("abandoned flag on a wrong byte");

endmodule
